// ===== rtl/gcm_pkg.sv =====
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared sizes, codes and channel word types of the grid collision map.
// ----------------------------------------------------------------------------
package gcm_pkg;

    localparam int MAX_COLS       = 64;
    localparam int MAX_ROWS       = 64;
    localparam int ID_BITS        = 8;
    localparam int ID_COUNT       = 1 << ID_BITS;
    localparam int RESULT_CAP     = 64;

    localparam int COL_CW         = $clog2(MAX_COLS + 1);
    localparam int ROW_CW         = $clog2(MAX_ROWS + 1);
    localparam int CELL_ADDR_BITS = $clog2(MAX_COLS * MAX_ROWS);
    localparam int CNT_BITS       = $clog2(RESULT_CAP + 1);
    localparam int SPAN_BITS      = 10;

    // opcodes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_ERASE = 3'd1;
    localparam logic [2:0] OP_MOVE  = 3'd2;
    localparam logic [2:0] OP_CHECK = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    // directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // block reasons
    localparam logic [1:0] RSN_NONE     = 2'd0;
    localparam logic [1:0] RSN_WORLD    = 2'd1;
    localparam logic [1:0] RSN_SCREEN   = 2'd2;
    localparam logic [1:0] RSN_COLLIDER = 2'd3;

    // register indexes
    localparam logic [1:0] REG_COLS   = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;
    localparam logic [1:0] REG_MARGIN = 2'd2;

    typedef logic signed [SPAN_BITS-1:0] t_span;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        obj_id;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [6:0]        area_width;
        logic [6:0]        area_height;
        logic [1:0]        direction;
        logic              is_collider;
        logic              may_leave_screen;
    } t_item;

    typedef struct packed {
        logic       allowed;
        logic [1:0] block_reason;
        logic [7:0] hit_id;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0] reg_index;
        logic [6:0] wdata;
    } t_cfg;

endpackage

// ===== rtl/gcm_item_if.sv =====
// ----------------------------------------------------------------------------
// gcm_item_if
// Item channel: one grid operation per word.
// ----------------------------------------------------------------------------
interface gcm_item_if;
    logic          valid;
    logic          ready;
    gcm_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gcm_res_if.sv =====
// ----------------------------------------------------------------------------
// gcm_res_if
// Result channel: one check or query result per word.
// ----------------------------------------------------------------------------
interface gcm_res_if;
    logic         valid;
    logic         ready;
    gcm_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gcm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gcm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gcm_cfg_if;
    logic         valid;
    logic         ready;
    gcm_pkg::t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/grid_collision_map.sv =====
// ----------------------------------------------------------------------------
// grid_collision_map
// Occupancy grid of collider ids with area fill, move and collision scans.
// ----------------------------------------------------------------------------
//  channel  | dir | word                         | handshake
//  ---------+-----+------------------------------+-----------
//  i_item   | in  | opcode, object rectangle     | valid/ready
//  o_res    | out | allowed, reason, hit id, last| valid/ready
//  i_cfg    | in  | register index, write data   | valid/ready (always ready)
//
//  Write/erase: rectangle and clip states, then each clipped cell written in turn
//  (one RAM write port). Move: two such line passes, leading line written, then
//  trailing line cleared. Check/query: rectangle and clip states, then per scanned
//  cell a registered RAM read and a seen-id test, plus result stalls.
//  After reset and after any grid size write the grid is cleared at one cell
//  per cycle, during which no item is taken.
//  A full result register stalls the scan only when a new id must be handed out.
// ----------------------------------------------------------------------------
module grid_collision_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gcm_item_if.sink    i_item,
    gcm_res_if.source   o_res,
    gcm_cfg_if.sink     i_cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RECT = 3'd1;
    localparam logic [2:0] S_CLIP = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_CK   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam int CELLS = gcm_pkg::MAX_COLS * gcm_pkg::MAX_ROWS;

    function automatic logic [gcm_pkg::COL_CW-1:0] clamp_cols(input logic [6:0] v);
        logic [gcm_pkg::COL_CW-1:0] s;
        if (v == 7'd0) begin
            s = gcm_pkg::COL_CW'(1);
        end else if (int'(v) > gcm_pkg::MAX_COLS) begin
            s = gcm_pkg::COL_CW'(gcm_pkg::MAX_COLS);
        end else begin
            s = gcm_pkg::COL_CW'(v);
        end
        return s;
    endfunction

    function automatic logic [gcm_pkg::ROW_CW-1:0] clamp_rows(input logic [6:0] v);
        logic [gcm_pkg::ROW_CW-1:0] s;
        if (v == 7'd0) begin
            s = gcm_pkg::ROW_CW'(1);
        end else if (int'(v) > gcm_pkg::MAX_ROWS) begin
            s = gcm_pkg::ROW_CW'(gcm_pkg::MAX_ROWS);
        end else begin
            s = gcm_pkg::ROW_CW'(v);
        end
        return s;
    endfunction

    // control
    logic [2:0]                          r_state;
    logic                                r_phase;
    logic                                r_clr_busy;
    logic [gcm_pkg::CELL_ADDR_BITS-1:0]  r_clr_addr;
    logic [gcm_pkg::COL_CW-1:0]          r_cols;
    logic [gcm_pkg::ROW_CW-1:0]          r_rows;
    logic [4:0]                          r_margin;
    logic [gcm_pkg::ID_COUNT-1:0]        r_seen;
    logic                                r_pend_v;
    logic [gcm_pkg::CNT_BITS-1:0]        r_cnt;
    logic                                r_out_v;

    // item and geometry
    gcm_pkg::t_item                      r_item;
    gcm_pkg::t_span                      r_rx0, r_ry0, r_to, r_edge, r_mline;
    logic [6:0]                          r_rw, r_rh;
    logic [gcm_pkg::ID_BITS-1:0]         r_fill;
    logic [gcm_pkg::COL_CW-1:0]          r_xa, r_xb, r_cx;
    logic [gcm_pkg::ROW_CW-1:0]          r_yb, r_cy;
    logic [gcm_pkg::ID_BITS-1:0]         r_pend_id;
    logic                                r_fin_allowed;
    logic [1:0]                          r_fin_reason;
    gcm_pkg::t_res                       r_out;

    // grid memory
    logic [gcm_pkg::ID_BITS-1:0]         r_mem [CELLS];
    logic [gcm_pkg::ID_BITS-1:0]         r_rd_data;

    gcm_pkg::t_span                      n_rx0, n_ry0, n_to, n_edge, n_mline;
    logic [6:0]                          n_rw, n_rh;
    logic [gcm_pkg::ID_BITS-1:0]         n_fill;
    logic                                n_skip;

    gcm_pkg::t_span                      w_px, w_py, w_pw, w_ph, w_one;
    gcm_pkg::t_span                      w_cols, w_rows, w_marg;
    gcm_pkg::t_span                      w_x1, w_y1, w_xa, w_xb, w_ya, w_yb;
    logic                                w_empty;
    logic [gcm_pkg::CELL_ADDR_BITS-1:0]  w_cell;
    logic                                w_we;
    logic [gcm_pkg::CELL_ADDR_BITS-1:0]  w_waddr;
    logic [gcm_pkg::ID_BITS-1:0]         w_wdata;
    logic                                w_x_end, w_y_end;
    logic                                w_new, w_out_free, w_stall, w_emit;
    logic                                w_accept, w_cfg_wr, w_size_wr;
    logic                                w_scan_op;

    assign i_item.ready = (r_state == S_IDLE) && !r_clr_busy;
    assign i_cfg.ready  = 1'b1;
    assign o_res.valid  = r_out_v;
    assign o_res.data   = r_out;

    assign w_accept  = i_item.valid && i_item.ready;
    assign w_cfg_wr  = i_cfg.valid && i_cfg.ready;
    assign w_size_wr = w_cfg_wr && ((i_cfg.data.reg_index == gcm_pkg::REG_COLS) ||
                                    (i_cfg.data.reg_index == gcm_pkg::REG_ROWS));

    assign w_px   = gcm_pkg::t_span'(r_item.pos_x);
    assign w_py   = gcm_pkg::t_span'(r_item.pos_y);
    assign w_pw   = gcm_pkg::t_span'(r_item.area_width);
    assign w_ph   = gcm_pkg::t_span'(r_item.area_height);
    assign w_one  = gcm_pkg::t_span'(1);
    assign w_cols = gcm_pkg::t_span'(r_cols);
    assign w_rows = gcm_pkg::t_span'(r_rows);
    assign w_marg = gcm_pkg::t_span'(r_margin);

    // raw rectangle for the current pass; the leading line is shared by move and check
    always_comb begin
        n_rx0   = w_px;
        n_ry0   = w_py;
        n_rw    = r_item.area_width;
        n_rh    = r_item.area_height;
        n_fill  = gcm_pkg::ID_BITS'(r_item.obj_id);
        n_to    = '0;
        n_edge  = '0;
        n_mline = '0;
        n_skip  = 1'b0;
        case (r_item.opcode)
            gcm_pkg::OP_WRITE: begin
                n_skip = !r_item.is_collider;
            end
            gcm_pkg::OP_ERASE: begin
                n_skip = !r_item.is_collider;
                n_fill = '0;
            end
            gcm_pkg::OP_MOVE, gcm_pkg::OP_CHECK: begin
                n_skip = (r_item.opcode == gcm_pkg::OP_MOVE) && !r_item.is_collider;
                if (r_phase) begin
                    n_fill = '0;
                end
                case (r_item.direction)
                    gcm_pkg::DIR_UP: begin
                        n_ry0   = r_phase ? w_py : w_py + w_ph;
                        n_rh    = 7'd1;
                        n_to    = w_py + w_ph;
                        n_edge  = w_rows;
                        n_mline = w_rows - w_marg;
                    end
                    gcm_pkg::DIR_DOWN: begin
                        n_ry0   = r_phase ? w_py + w_ph - w_one : w_py - w_one;
                        n_rh    = 7'd1;
                        n_to    = w_py - w_one;
                        n_edge  = -w_one;
                        n_mline = w_marg - w_one;
                    end
                    gcm_pkg::DIR_RIGHT: begin
                        n_rx0   = r_phase ? w_px : w_px + w_pw;
                        n_rw    = 7'd1;
                        n_to    = w_px + w_pw;
                        n_edge  = w_cols;
                        n_mline = w_cols - w_marg;
                    end
                    default: begin
                        n_rx0   = r_phase ? w_px + w_pw - w_one : w_px - w_one;
                        n_rw    = 7'd1;
                        n_to    = w_px - w_one;
                        n_edge  = -w_one;
                        n_mline = w_marg - w_one;
                    end
                endcase
            end
            gcm_pkg::OP_QUERY: begin
                n_skip = 1'b0;
            end
            default: begin
                n_skip = 1'b1;
            end
        endcase
    end

    // clip to the grid in use
    assign w_x1    = r_rx0 + gcm_pkg::t_span'(r_rw);
    assign w_y1    = r_ry0 + gcm_pkg::t_span'(r_rh);
    assign w_xa    = (r_rx0 < 0) ? '0 : r_rx0;
    assign w_ya    = (r_ry0 < 0) ? '0 : r_ry0;
    assign w_xb    = (w_x1 > w_cols) ? w_cols : w_x1;
    assign w_yb    = (w_y1 > w_rows) ? w_rows : w_y1;
    assign w_empty = (w_xa >= w_xb) || (w_ya >= w_yb);

    assign w_scan_op = (r_item.opcode == gcm_pkg::OP_CHECK) ||
                       (r_item.opcode == gcm_pkg::OP_QUERY);

    assign w_cell  = gcm_pkg::CELL_ADDR_BITS'(r_cy * gcm_pkg::MAX_COLS + r_cx);
    assign w_x_end = (r_cx + gcm_pkg::COL_CW'(1)) == r_xb;
    assign w_y_end = (r_cy + gcm_pkg::ROW_CW'(1)) == r_yb;

    assign w_out_free = !r_out_v || o_res.ready;
    assign w_new      = (r_rd_data != '0) && !r_seen[r_rd_data] &&
                        (r_cnt < gcm_pkg::CNT_BITS'(gcm_pkg::RESULT_CAP));
    assign w_stall    = w_new && r_pend_v && !w_out_free;
    assign w_emit     = ((r_state == S_CK) && !w_stall && w_new && r_pend_v) ||
                        ((r_state == S_DONE) && w_out_free);

    assign w_we    = r_clr_busy || (r_state == S_WR);
    assign w_waddr = r_clr_busy ? r_clr_addr : w_cell;
    assign w_wdata = r_clr_busy ? '0 : r_fill;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_cell];
    end

    // control path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_cols     <= gcm_pkg::COL_CW'(gcm_pkg::MAX_COLS);
            r_rows     <= gcm_pkg::ROW_CW'(gcm_pkg::MAX_ROWS);
            r_margin   <= '0;
            r_seen     <= '0;
            r_pend_v   <= 1'b0;
            r_cnt      <= '0;
            r_out_v    <= 1'b0;
        end else begin
            // clearing pass, restarted by a grid size write
            if (w_size_wr) begin
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == gcm_pkg::CELL_ADDR_BITS'(CELLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_cfg_wr) begin
                case (i_cfg.data.reg_index)
                    gcm_pkg::REG_COLS: begin
                        r_cols <= clamp_cols(i_cfg.data.wdata);
                    end
                    gcm_pkg::REG_ROWS: begin
                        r_rows <= clamp_rows(i_cfg.data.wdata);
                    end
                    gcm_pkg::REG_MARGIN: begin
                        r_margin <= i_cfg.data.wdata[4:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (w_emit) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_phase <= 1'b0;
                        r_state <= S_RECT;
                    end
                end
                S_RECT: begin
                    r_state <= n_skip ? S_IDLE : S_CLIP;
                end
                S_CLIP: begin
                    if (w_scan_op) begin
                        r_seen   <= '0;
                        r_pend_v <= 1'b0;
                        r_cnt    <= '0;
                    end
                    if (r_item.opcode == gcm_pkg::OP_CHECK &&
                        (r_to == r_edge || (!r_item.may_leave_screen && r_to == r_mline) ||
                         !r_item.is_collider)) begin
                        r_state <= S_DONE;
                    end else if (w_empty) begin
                        if (w_scan_op) begin
                            r_state <= S_DONE;
                        end else if (r_item.opcode == gcm_pkg::OP_MOVE && !r_phase) begin
                            r_phase <= 1'b1;
                            r_state <= S_RECT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= w_scan_op ? S_RD : S_WR;
                    end
                end
                S_WR: begin
                    if (w_x_end && w_y_end) begin
                        if (r_item.opcode == gcm_pkg::OP_MOVE && !r_phase) begin
                            r_phase <= 1'b1;
                            r_state <= S_RECT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CK;
                end
                S_CK: begin
                    if (!w_stall) begin
                        if (w_new) begin
                            r_seen[r_rd_data] <= 1'b1;
                            r_pend_v          <= 1'b1;
                            r_cnt             <= r_cnt + 1'b1;
                        end
                        r_state <= (w_x_end && w_y_end) ? S_DONE : S_RD;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item.data;
        end
        if (r_state == S_RECT) begin
            r_rx0   <= n_rx0;
            r_ry0   <= n_ry0;
            r_rw    <= n_rw;
            r_rh    <= n_rh;
            r_fill  <= n_fill;
            r_to    <= n_to;
            r_edge  <= n_edge;
            r_mline <= n_mline;
        end
        if (r_state == S_CLIP) begin
            r_xa <= gcm_pkg::COL_CW'(w_xa);
            r_xb <= gcm_pkg::COL_CW'(w_xb);
            r_yb <= gcm_pkg::ROW_CW'(w_yb);
            r_cx <= gcm_pkg::COL_CW'(w_xa);
            r_cy <= gcm_pkg::ROW_CW'(w_ya);
            // query has no edge tests
            if (r_item.opcode != gcm_pkg::OP_CHECK) begin
                r_fin_allowed <= 1'b1;
                r_fin_reason  <= gcm_pkg::RSN_NONE;
            end else if (r_to == r_edge) begin
                r_fin_allowed <= 1'b0;
                r_fin_reason  <= gcm_pkg::RSN_WORLD;
            end else if (!r_item.may_leave_screen && r_to == r_mline) begin
                r_fin_allowed <= 1'b0;
                r_fin_reason  <= gcm_pkg::RSN_SCREEN;
            end else begin
                r_fin_allowed <= 1'b1;
                r_fin_reason  <= gcm_pkg::RSN_NONE;
            end
        end
        // advance over the clipped rectangle, rows bottom up
        if ((r_state == S_WR) || (r_state == S_CK && !w_stall)) begin
            if (w_x_end) begin
                r_cx <= r_xa;
                r_cy <= r_cy + 1'b1;
            end else begin
                r_cx <= r_cx + 1'b1;
            end
        end
        if (r_state == S_CK && !w_stall && w_new) begin
            r_pend_id <= r_rd_data;
            if (r_pend_v) begin
                r_out.allowed      <= 1'b0;
                r_out.block_reason <= gcm_pkg::RSN_COLLIDER;
                r_out.hit_id       <= 8'(r_pend_id);
                r_out.last         <= 1'b0;
            end
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out.last <= 1'b1;
            if (r_pend_v) begin
                r_out.allowed      <= 1'b0;
                r_out.block_reason <= gcm_pkg::RSN_COLLIDER;
                r_out.hit_id       <= 8'(r_pend_id);
            end else begin
                r_out.allowed      <= r_fin_allowed;
                r_out.block_reason <= r_fin_reason;
                r_out.hit_id       <= '0;
            end
        end
    end

    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_item.ready)
        else $error("item accepted during grid clear");

    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= gcm_pkg::CNT_BITS'(gcm_pkg::RESULT_CAP))
        else $error("result count above cap");

    a_pending_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v && (r_state == S_CK || r_state == S_DONE) |-> r_pend_id != '0)
        else $error("pending hit id is empty");

    a_scan_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CK || r_state == S_WR) |->
            (r_cx < r_xb) && (r_cy < r_yb))
        else $error("cell pointer outside clipped rectangle");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_out_free |=> r_out_v && r_out.last)
        else $error("final result not issued");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for grid_collision_map. A scoreboard keeps its own copy
// of the occupancy grid and the size and margin registers, and works out the
// result words of every accepted check or query word. Directed words cover
// clipping, moves, every edge test and two of the unused opcodes. Random object walks
// and loose words follow across several grid settings, including a long
// result-side hold-off and a run of more than 64 distinct ids.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SETTLE_CYCLES    = 4200;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int LIMIT_CYCLES     = 20000000;
    localparam int REPORT_CAP       = 200;
    localparam logic [1:0] REG_SPARE = 2'd3;

    class grid_scoreboard;
        logic [7:0]    owner [gcm_pkg::MAX_COLS*gcm_pkg::MAX_ROWS];
        bit            seen  [gcm_pkg::ID_COUNT];
        int            grid_cols;
        int            grid_rows;
        int            margin;
        gcm_pkg::t_res awaited_verdicts[$];
        int            fails;

        function new();
            clear_grid();
            grid_cols = gcm_pkg::MAX_COLS;
            grid_rows = gcm_pkg::MAX_ROWS;
            margin    = 0;
            fails     = 0;
        endfunction

        function void clear_grid();
            foreach (owner[i]) owner[i] = '0;
        endfunction

        function int clamp_dim(logic [6:0] v, int maxv);
            int s = v;
            if (s < 1) s = 1;
            if (s > maxv) s = maxv;
            return s;
        endfunction

        function void set_register(logic [1:0] idx, logic [6:0] val);
            case (idx)
                gcm_pkg::REG_COLS: begin
                    grid_cols = clamp_dim(val, gcm_pkg::MAX_COLS);
                    clear_grid();
                end
                gcm_pkg::REG_ROWS: begin
                    grid_rows = clamp_dim(val, gcm_pkg::MAX_ROWS);
                    clear_grid();
                end
                gcm_pkg::REG_MARGIN: margin = val[4:0];
                default: ;
            endcase
        endfunction

        // fill a rectangle clipped to the grid; id 0 clears it
        function void fill_cells(int x0, int y0, int w, int h, logic [7:0] id);
            int xa = x0 < 0 ? 0 : x0;
            int ya = y0 < 0 ? 0 : y0;
            int xb = x0 + w > grid_cols ? grid_cols : x0 + w;
            int yb = y0 + h > grid_rows ? grid_rows : y0 + h;
            for (int y = ya; y < yb; y++)
                for (int x = xa; x < xb; x++)
                    owner[y*gcm_pkg::MAX_COLS + x] = id;
        endfunction

        function void push_verdict(logic ok, logic [1:0] why);
            gcm_pkg::t_res r;
            r.allowed      = ok;
            r.block_reason = why;
            r.hit_id       = '0;
            r.last         = 1'b1;
            awaited_verdicts.push_back(r);
        endfunction

        // distinct ids in scan order: rows bottom up, columns left to right
        function void scan_cells(int x0, int y0, int w, int h);
            int xa = x0 < 0 ? 0 : x0;
            int ya = y0 < 0 ? 0 : y0;
            int xb = x0 + w > grid_cols ? grid_cols : x0 + w;
            int yb = y0 + h > grid_rows ? grid_rows : y0 + h;
            gcm_pkg::t_res found[$];
            gcm_pkg::t_res r;
            logic [7:0] id;
            foreach (seen[i]) seen[i] = 1'b0;
            for (int y = ya; y < yb; y++)
                for (int x = xa; x < xb; x++) begin
                    id = owner[y*gcm_pkg::MAX_COLS + x];
                    if (id != 0 && !seen[id] && found.size() < gcm_pkg::RESULT_CAP) begin
                        seen[id]       = 1'b1;
                        r.allowed      = 1'b0;
                        r.block_reason = gcm_pkg::RSN_COLLIDER;
                        r.hit_id       = id;
                        r.last         = 1'b0;
                        found.push_back(r);
                    end
                end
            if (found.size() == 0) begin
                push_verdict(1'b1, gcm_pkg::RSN_NONE);
            end else begin
                found[found.size()-1].last = 1'b1;
                foreach (found[i]) awaited_verdicts.push_back(found[i]);
            end
        endfunction

        function void take_item(gcm_pkg::t_item it);
            int px = $signed(it.pos_x);
            int py = $signed(it.pos_y);
            int w  = it.area_width;
            int h  = it.area_height;
            int dest = 0;
            int wall = 0;
            int margin_line = 0;
            logic [7:0] id = it.obj_id;
            case (it.opcode)
                gcm_pkg::OP_WRITE: if (it.is_collider) fill_cells(px, py, w, h, id);
                gcm_pkg::OP_ERASE: if (it.is_collider) fill_cells(px, py, w, h, '0);
                gcm_pkg::OP_MOVE: begin
                    if (it.is_collider) begin
                        // write the leading line, then clear the trailing one
                        case (it.direction)
                            gcm_pkg::DIR_UP: begin
                                fill_cells(px, py + h, w, 1, id);
                                fill_cells(px, py, w, 1, '0);
                            end
                            gcm_pkg::DIR_DOWN: begin
                                fill_cells(px, py - 1, w, 1, id);
                                fill_cells(px, py + h - 1, w, 1, '0);
                            end
                            gcm_pkg::DIR_RIGHT: begin
                                fill_cells(px + w, py, 1, h, id);
                                fill_cells(px, py, 1, h, '0);
                            end
                            default: begin
                                fill_cells(px - 1, py, 1, h, id);
                                fill_cells(px + w - 1, py, 1, h, '0);
                            end
                        endcase
                    end
                end
                gcm_pkg::OP_CHECK: begin
                    case (it.direction)
                        gcm_pkg::DIR_UP: begin
                            dest = py + h; wall = grid_rows; margin_line = grid_rows - margin;
                        end
                        gcm_pkg::DIR_DOWN: begin
                            dest = py - 1; wall = -1; margin_line = margin - 1;
                        end
                        gcm_pkg::DIR_RIGHT: begin
                            dest = px + w; wall = grid_cols; margin_line = grid_cols - margin;
                        end
                        default: begin
                            dest = px - 1; wall = -1; margin_line = margin - 1;
                        end
                    endcase
                    if (dest == wall)
                        push_verdict(1'b0, gcm_pkg::RSN_WORLD);
                    else if (!it.may_leave_screen && dest == margin_line)
                        push_verdict(1'b0, gcm_pkg::RSN_SCREEN);
                    else if (!it.is_collider)
                        push_verdict(1'b1, gcm_pkg::RSN_NONE);
                    else if (it.direction == gcm_pkg::DIR_UP ||
                             it.direction == gcm_pkg::DIR_DOWN)
                        scan_cells(px, dest, w, 1);
                    else
                        scan_cells(dest, py, 1, h);
                end
                gcm_pkg::OP_QUERY: scan_cells(px, py, w, h);
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (fails < REPORT_CAP) $display("mismatch: %s", msg);
            fails++;
        endtask

        task match_verdict(gcm_pkg::t_res got);
            gcm_pkg::t_res want;
            if (awaited_verdicts.size() == 0) begin
                report($sformatf("word with nothing awaited: allowed %0b reason %0d hit %0d last %0b",
                                 got.allowed, got.block_reason, got.hit_id, got.last));
                return;
            end
            want = awaited_verdicts.pop_front();
            if (got.allowed !== want.allowed)
                report($sformatf("allowed %0b, want %0b", got.allowed, want.allowed));
            if (got.block_reason !== want.block_reason)
                report($sformatf("block_reason %0d, want %0d", got.block_reason,
                                 want.block_reason));
            if (got.hit_id !== want.hit_id)
                report($sformatf("hit_id %0d, want %0d", got.hit_id, want.hit_id));
            if (got.last !== want.last)
                report($sformatf("last %0b, want %0b", got.last, want.last));
        endtask

        task leftovers();
            if (awaited_verdicts.size() != 0)
                report($sformatf("%0d words never arrived", awaited_verdicts.size()));
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gcm_item_if item_bus();
    gcm_res_if  res_bus();
    gcm_cfg_if  cfg_bus();

    grid_collision_map dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    grid_scoreboard sb = new();
    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;
    int items_sent    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check at the rising edge, pick ready at the falling edge
    initial begin
        int stall_left;
        stall_left = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_bus.valid && res_bus.ready) sb.match_verdict(res_bus.data);
            @(negedge i_clk);
            if (long_hold_req) begin
                res_bus.ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            if (stall_left > 0) begin
                res_bus.ready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_bus.ready = 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                res_bus.ready = 1'b1;
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic gcm_pkg::t_item grid_op(logic [2:0] op, logic [7:0] id, int x, int y,
                                               int w, int h, logic [1:0] dir, bit coll,
                                               bit leave);
        gcm_pkg::t_item it;
        it.opcode           = op;
        it.obj_id           = id;
        it.pos_x            = 8'(x);
        it.pos_y            = 8'(y);
        it.area_width       = 7'(w);
        it.area_height      = 7'(h);
        it.direction        = dir;
        it.is_collider      = coll;
        it.may_leave_screen = leave;
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(gcm_pkg::t_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            item_bus.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        item_bus.valid = 1'b1;
        item_bus.data  = it;
        do @(posedge i_clk); while (!item_bus.ready);
        sb.take_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_bus.valid          = 1'b1;
        cfg_bus.data.reg_index = idx;
        cfg_bus.data.wdata     = val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_register(idx, val);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic wait_drain();
        item_bus.valid = 1'b0;
        while (sb.awaited_verdicts.size() != 0) @(negedge i_clk);
    endtask

    // let a trailing fill or move finish before touching the registers
    task automatic phase_break();
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int pick_size();
        if ($urandom_range(0, 29) == 0) return $urandom_range(0, 127);
        return $urandom_range(1, 6);
    endfunction

    function automatic gcm_pkg::t_item random_op();
        gcm_pkg::t_item it;
        logic [63:0] noise;
        int pick = $urandom_range(0, 99);
        int cols = sb.grid_cols;
        int rows = sb.grid_rows;
        int w = pick_size();
        int h = pick_size();
        int x = int'($urandom_range(0, cols + 3)) - 2;
        int y = int'($urandom_range(0, rows + 3)) - 2;
        logic [1:0] dir = 2'($urandom_range(0, 3));
        logic [7:0] id = ($urandom_range(0, 40) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        bit coll = ($urandom_range(0, 9) != 0);
        bit leave = 1'($urandom_range(0, 1));
        bit at_margin = 1'($urandom_range(0, 1));
        if (pick < 6) begin
            noise = {$urandom, $urandom};
            it = noise[$bits(gcm_pkg::t_item)-1:0];
            return it;
        end
        if (pick < 30) return grid_op(gcm_pkg::OP_WRITE, id, x, y, w, h, dir, coll, leave);
        if (pick < 38) return grid_op(gcm_pkg::OP_ERASE, id, x, y, w, h, dir, coll, leave);
        if (pick < 55) return grid_op(gcm_pkg::OP_MOVE, id, x, y, w, h, dir, coll, leave);
        if (pick < 82) begin
            // aim a third of the checks at the world edge or the margin line
            if ($urandom_range(0, 2) == 0) begin
                case (dir)
                    gcm_pkg::DIR_UP:    y = (at_margin ? rows - sb.margin : rows) - h;
                    gcm_pkg::DIR_DOWN:  y = at_margin ? sb.margin : 0;
                    gcm_pkg::DIR_RIGHT: x = (at_margin ? cols - sb.margin : cols) - w;
                    default:            x = at_margin ? sb.margin : 0;
                endcase
            end
            return grid_op(gcm_pkg::OP_CHECK, id, x, y, w, h, dir, coll, leave);
        end
        return grid_op(gcm_pkg::OP_QUERY, id, x, y, w, h, dir, coll, leave);
    endfunction

    // place an object, step it around with a check before each move
    task automatic object_walk();
        int w = $urandom_range(1, 4);
        int h = $urandom_range(1, 4);
        int x = $urandom_range(0, sb.grid_cols - 1);
        int y = $urandom_range(0, sb.grid_rows - 1);
        logic [7:0] id = 8'($urandom_range(1, 255));
        logic [1:0] dir;
        bit leave;
        send_item(grid_op(gcm_pkg::OP_WRITE, id, x, y, w, h, gcm_pkg::DIR_UP, 1'b1, 1'b0));
        repeat ($urandom_range(2, 6)) begin
            dir   = 2'($urandom_range(0, 3));
            leave = 1'($urandom_range(0, 1));
            send_item(grid_op(gcm_pkg::OP_CHECK, id, x, y, w, h, dir, 1'b1, leave));
            send_item(grid_op(gcm_pkg::OP_MOVE, id, x, y, w, h, dir, 1'b1, leave));
            case (dir)
                gcm_pkg::DIR_UP:    y++;
                gcm_pkg::DIR_DOWN:  y--;
                gcm_pkg::DIR_RIGHT: x++;
                default:            x--;
            endcase
        end
        if ($urandom_range(0, 1))
            send_item(grid_op(gcm_pkg::OP_ERASE, id, x, y, w, h, gcm_pkg::DIR_UP,
                              1'b1, 1'b0));
    endtask

    task automatic run_random(int count);
        int goal = items_sent + count;
        while (items_sent < goal) begin
            if ($urandom_range(0, 1)) object_walk();
            else send_item(random_op());
        end
    endtask

    task automatic directed_items();
        send_item(grid_op(gcm_pkg::OP_WRITE, 8'hAA, 10, 10, 4, 3, gcm_pkg::DIR_UP, 1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_WRITE, 8'h55, 62, 62, 5, 5, gcm_pkg::DIR_UP, 1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_WRITE, 8'h01, -3, -2, 5, 4, gcm_pkg::DIR_UP, 1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_WRITE, 8'hFF, 20, 20, 2, 2, gcm_pkg::DIR_UP, 1'b0, 1'b0));
        send_item(grid_op(gcm_pkg::OP_QUERY, 8'h00, 0, 0, 64, 64, gcm_pkg::DIR_UP, 1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_QUERY, 8'h00, 10, 10, 0, 4, gcm_pkg::DIR_UP, 1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_MOVE, 8'hAA, 10, 10, 4, 3, gcm_pkg::DIR_UP, 1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_MOVE, 8'hAA, 10, 11, 4, 3, gcm_pkg::DIR_RIGHT,
                          1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_MOVE, 8'hAA, 11, 11, 4, 3, gcm_pkg::DIR_DOWN,
                          1'b1, 1'b0));
        // world edge in every direction
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 5, 60, 2, 4, gcm_pkg::DIR_UP, 1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 5, 0, 2, 2, gcm_pkg::DIR_DOWN, 1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 62, 5, 2, 2, gcm_pkg::DIR_RIGHT,
                          1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 0, 5, 2, 2, gcm_pkg::DIR_LEFT, 1'b1, 1'b1));
        // screen margin, then the same line for an object that may leave
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 5, 58, 2, 4, gcm_pkg::DIR_UP, 1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 62, 58, 2, 4, gcm_pkg::DIR_UP, 1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 4, 2, 2, 2, gcm_pkg::DIR_DOWN, 1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 60, 20, 2, 2, gcm_pkg::DIR_RIGHT,
                          1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 2, 5, 2, 2, gcm_pkg::DIR_LEFT, 1'b1, 1'b0));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 30, 30, 2, 2, gcm_pkg::DIR_UP, 1'b0, 1'b1));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h10, 9, 10, 2, 3, gcm_pkg::DIR_RIGHT,
                          1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_ERASE, 8'hAA, 11, 10, 4, 3, gcm_pkg::DIR_UP, 1'b1, 1'b0));
        send_item(grid_op(3'd5, 8'h33, 0, 0, 8, 8, gcm_pkg::DIR_UP, 1'b1, 1'b0));
        send_item(grid_op(3'd7, 8'h33, 0, 0, 8, 8, gcm_pkg::DIR_LEFT, 1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_QUERY, 8'h00, 0, 0, 64, 64, gcm_pkg::DIR_UP, 1'b1, 1'b1));
    endtask

    // more distinct ids than one scan may report, with the result side held off
    task automatic crowd_phase();
        for (int i = 0; i < 70; i++)
            send_item(grid_op(gcm_pkg::OP_WRITE, 8'(i + 1), i % 64, i / 64, 1, 1,
                              gcm_pkg::DIR_UP, 1'b1, 1'b0));
        long_hold_req = 1'b1;
        repeat (4) send_item(grid_op(gcm_pkg::OP_QUERY, 8'h00, 0, 0, 64, 2, gcm_pkg::DIR_UP,
                                     1'b1, 1'b1));
        send_item(grid_op(gcm_pkg::OP_CHECK, 8'h80, 0, 2, 64, 1, gcm_pkg::DIR_DOWN,
                          1'b1, 1'b1));
    endtask

    initial begin
        item_bus.valid = 1'b0;
        item_bus.data  = '0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.data   = '0;
        i_rst_n        = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(gcm_pkg::REG_MARGIN, 7'd2);
        write_reg(REG_SPARE, 7'h55);
        directed_items();

        phase_break();
        write_reg(gcm_pkg::REG_COLS, 7'd16);
        write_reg(gcm_pkg::REG_ROWS, 7'd12);
        write_reg(gcm_pkg::REG_MARGIN, 7'd3);
        run_random(45);
        wait_drain();
        run_random(45);

        phase_break();
        write_reg(gcm_pkg::REG_COLS, 7'd0);
        write_reg(gcm_pkg::REG_ROWS, 7'd127);
        write_reg(gcm_pkg::REG_MARGIN, 7'd31);
        run_random(40);

        phase_break();
        write_reg(gcm_pkg::REG_COLS, 7'd64);
        write_reg(gcm_pkg::REG_ROWS, 7'd1);
        write_reg(gcm_pkg::REG_MARGIN, 7'd0);
        run_random(50);

        phase_break();
        write_reg(gcm_pkg::REG_ROWS, 7'd64);
        write_reg(gcm_pkg::REG_MARGIN, 7'd5);
        crowd_phase();

        phase_break();
        quiet = 1'b1;
        write_reg(gcm_pkg::REG_COLS, 7'd32);
        write_reg(gcm_pkg::REG_ROWS, 7'd24);
        write_reg(gcm_pkg::REG_MARGIN, 7'd4);
        run_random(80);

        phase_break();
        sb.leftovers();
        if (sb.fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
